@@ sv/rplt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rplt_pkg
// Shared types and constants of the signal-strength peak lap timer.
// ----------------------------------------------------------------------------
package rplt_pkg;

  // Field widths
  localparam int LEVEL_W = 9;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int INDEX_W = 4;

  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic [TIME_W-1:0]         time_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [INDEX_W-1:0]        index_t;

  // Request function codes
  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_LAP   = 2'd2,
    EV_READ  = 2'd3
  } event_t;

  // Signal floor: a pass needs a sample strictly above this to count
  localparam level_t LEVEL_FLOOR = -9'sd150;

  // Saturation value of the lap counter
  localparam count_t LAP_COUNT_MAX = '1;

  // Default number of stored lap times
  localparam int HISTORY_DEPTH_DEF = 16;

endpackage
`default_nettype wire

@@ sv/rssi_peak_lap_timer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssi_peak_lap_timer_top
// Lap timer for one competitor: tracks the signal peak of each gate pass,
// turns pass times into lap times, keeps best lap, lap count and a lap
// history held in a RAM that can be read back by index.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   func, signal_level, sample_time,
//                                           pass_end, history_index
//   out      output     out_valid/out_stall event_res, lap_time,
//                                           best_lap_time, lap_count,
//                                           lap_level, entry_valid
//   cfg      input      cfg_we              cfg_wdata (pick_mode)
//
// One request per cycle while in_stall is low; each result passes through
// the middle stage, which takes the history RAM read, and then the output
// register. Scalar state is updated at acceptance, so back-to-back requests
// see the previous request's effect; the history RAM's single read port sets
// the pace. Reset is synchronous; the history needs no sweep because the
// fill count marks which entries hold laps. When the output stalls, one more
// request is taken into the middle stage, then in_stall rises.
// ----------------------------------------------------------------------------
module rssi_peak_lap_timer_top #(
  parameter int HISTORY_DEPTH = rplt_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata,
  // request channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rplt_pkg::func_t  func,
  input  wire rplt_pkg::level_t signal_level,
  input  wire rplt_pkg::time_t  sample_time,
  input  wire logic             pass_end,
  input  wire rplt_pkg::index_t history_index,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rplt_pkg::event_t      event_res,
  output rplt_pkg::time_t       lap_time,
  output rplt_pkg::time_t       best_lap_time,
  output rplt_pkg::count_t      lap_count,
  output rplt_pkg::level_t      lap_level,
  output logic                  entry_valid
);

  import rplt_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

  // Competitor state
  logic          pick_mode;
  logic          timing_started, timing_started_next;
  time_t         prev_pass_time, prev_pass_time_next;
  time_t         last_lap, last_lap_next;
  time_t         best_lap, best_lap_next;
  count_t        laps_done, laps_done_next;
  level_t        last_peak_level, last_peak_level_next;
  level_t        pass_peak_level, pass_peak_level_next;
  time_t         pass_peak_time, pass_peak_time_next;
  time_t         pass_first_time, pass_first_time_next;
  logic          pass_has_sample, pass_has_sample_next;
  logic [AW-1:0] history_head, history_head_next;
  logic [FW-1:0] history_fill, history_fill_next;

  // Middle stage
  logic   s1_valid;
  event_t s1_event, s1_event_next;
  time_t  s1_lap, s1_best;
  count_t s1_count;
  level_t s1_level;
  logic   s1_read, s1_hit, s1_hit_next;

  // History RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  time_t         ram_rdata;

  logic accept, s1_move;

  // Working values of the pass update
  time_t         cur_first_time, cur_peak_time, pass_time, lap_new;
  level_t        cur_peak_level;
  logic          history_full;
  logic [SW-1:0] read_sum, write_sum;

  // Handshake
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  // Compute the next state of one request
  always_comb begin
    timing_started_next  = timing_started;
    prev_pass_time_next  = prev_pass_time;
    last_lap_next        = last_lap;
    best_lap_next        = best_lap;
    laps_done_next       = laps_done;
    last_peak_level_next = last_peak_level;
    pass_peak_level_next = pass_peak_level;
    pass_peak_time_next  = pass_peak_time;
    pass_first_time_next = pass_first_time;
    pass_has_sample_next = pass_has_sample;
    history_head_next    = history_head;
    history_fill_next    = history_fill;
    s1_event_next        = EV_NONE;
    s1_hit_next          = 1'b0;
    ram_we               = 1'b0;
    ram_re               = 1'b0;

    // Running first time and strict peak including this sample
    cur_first_time = pass_has_sample ? pass_first_time : sample_time;
    if (signal_level > pass_peak_level) begin
      cur_peak_level = signal_level;
      cur_peak_time  = sample_time;
    end else begin
      cur_peak_level = pass_peak_level;
      cur_peak_time  = pass_peak_time;
    end
    pass_time    = pick_mode ? cur_first_time : cur_peak_time;
    lap_new      = pass_time - prev_pass_time;
    history_full = (history_fill == FW'(HISTORY_DEPTH));

    // Push slot: at the head when full, else just past the newest entry
    write_sum = SW'(history_head) + SW'(history_fill);
    if (history_full) begin
      ram_waddr = history_head;
    end else if (write_sum >= SW'(HISTORY_DEPTH)) begin
      ram_waddr = AW'(write_sum - SW'(HISTORY_DEPTH));
    end else begin
      ram_waddr = AW'(write_sum);
    end

    // Read slot, relative to the oldest entry
    read_sum = SW'(history_head) + SW'(history_index);
    if (read_sum >= SW'(HISTORY_DEPTH)) begin
      ram_raddr = AW'(read_sum - SW'(HISTORY_DEPTH));
    end else begin
      ram_raddr = AW'(read_sum);
    end

    if (accept) begin
      unique case (func)
        FUNC_SAMPLE: begin
          pass_has_sample_next = 1'b1;
          pass_first_time_next = cur_first_time;
          pass_peak_level_next = cur_peak_level;
          pass_peak_time_next  = cur_peak_time;
          if (pass_end) begin
            if (cur_peak_level > LEVEL_FLOOR) begin
              if (!timing_started) begin
                timing_started_next = 1'b1;
                prev_pass_time_next = pass_time;
                s1_event_next       = EV_START;
              end else begin
                last_lap_next        = lap_new;
                prev_pass_time_next  = pass_time;
                last_peak_level_next = cur_peak_level;
                ram_we               = 1'b1;
                if (history_full) begin
                  history_head_next = (history_head == AW'(HISTORY_DEPTH - 1)) ?
                                      '0 : history_head + 1'b1;
                end else begin
                  history_fill_next = history_fill + 1'b1;
                end
                if (laps_done == '0 || lap_new < best_lap) begin
                  best_lap_next = lap_new;
                end
                if (laps_done != LAP_COUNT_MAX) begin
                  laps_done_next = laps_done + 1'b1;
                end
                s1_event_next = EV_LAP;
              end
            end
            // Drop the pass store
            pass_has_sample_next = 1'b0;
            pass_first_time_next = '0;
            pass_peak_level_next = LEVEL_FLOOR;
            pass_peak_time_next  = '0;
          end
        end
        FUNC_CLEAR: begin
          timing_started_next  = 1'b0;
          prev_pass_time_next  = '0;
          last_lap_next        = '0;
          best_lap_next        = '0;
          laps_done_next       = '0;
          last_peak_level_next = LEVEL_FLOOR;
          pass_peak_level_next = LEVEL_FLOOR;
          pass_peak_time_next  = '0;
          pass_first_time_next = '0;
          pass_has_sample_next = 1'b0;
          history_head_next    = '0;
          history_fill_next    = '0;
        end
        FUNC_READ: begin
          s1_event_next = EV_READ;
          s1_hit_next   = SW'(history_index) < SW'(history_fill);
          ram_re        = 1'b1;
        end
        FUNC_NONE: begin
          s1_event_next = EV_NONE;
        end
        default: begin
          s1_event_next = EV_NONE;
        end
      endcase
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pick_mode <= 1'b0;
    end else if (cfg_we) begin
      pick_mode <= cfg_wdata;
    end
  end

  // Competitor state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timing_started  <= 1'b0;
      prev_pass_time  <= '0;
      last_lap        <= '0;
      best_lap        <= '0;
      laps_done       <= '0;
      last_peak_level <= LEVEL_FLOOR;
      pass_peak_level <= LEVEL_FLOOR;
      pass_peak_time  <= '0;
      pass_first_time <= '0;
      pass_has_sample <= 1'b0;
      history_head    <= '0;
      history_fill    <= '0;
    end else begin
      timing_started  <= timing_started_next;
      prev_pass_time  <= prev_pass_time_next;
      last_lap        <= last_lap_next;
      best_lap        <= best_lap_next;
      laps_done       <= laps_done_next;
      last_peak_level <= last_peak_level_next;
      pass_peak_level <= pass_peak_level_next;
      pass_peak_time  <= pass_peak_time_next;
      pass_first_time <= pass_first_time_next;
      pass_has_sample <= pass_has_sample_next;
      history_head    <= history_head_next;
      history_fill    <= history_fill_next;
    end
  end

  // Lap history storage
  rplt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (lap_new),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Middle stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Middle stage payload: snapshot of the updated state
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_event <= s1_event_next;
      s1_lap   <= last_lap_next;
      s1_best  <= best_lap_next;
      s1_count <= laps_done_next;
      s1_level <= last_peak_level_next;
      s1_read  <= (func == FUNC_READ);
      s1_hit   <= s1_hit_next;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload, merge in the history entry on reads
  always_ff @(posedge clk) begin
    if (s1_move) begin
      event_res     <= s1_event;
      best_lap_time <= s1_best;
      lap_count     <= s1_count;
      lap_level     <= s1_level;
      entry_valid   <= s1_read && s1_hit;
      if (s1_read) begin
        lap_time <= s1_hit ? ram_rdata : '0;
      end else begin
        lap_time <= s1_lap;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/rplt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rplt_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rplt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ tb/lap_timer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lap_timer_checker
// Watches the request, result and register ports of the lap timer. Keeps its
// own copy of the timer state, predicts the result of every accepted request
// and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module lap_timer_checker
  import rplt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata,
  input  wire logic   in_valid,
  input  wire logic   in_stall,
  input  wire func_t  func,
  input  wire level_t signal_level,
  input  wire time_t  sample_time,
  input  wire logic   pass_end,
  input  wire index_t history_index,
  input  wire logic   out_valid,
  input  wire logic   out_stall,
  input  wire event_t event_res,
  input  wire time_t  lap_time,
  input  wire time_t  best_lap_time,
  input  wire count_t lap_count,
  input  wire level_t lap_level,
  input  wire logic   entry_valid,
  output int          pending,
  output int          fail_count
);

  localparam int DEPTH = HISTORY_DEPTH_DEF;

  typedef struct {
    event_t ev;
    time_t  lap;
    time_t  best;
    count_t count;
    level_t level;
    logic   valid;
  } lap_result_t;

  lap_result_t lap_results_due[$];

  // Timer state as the block should hold it
  logic   use_first_stamp;
  logic   started;
  time_t  prev_pass_stamp;
  time_t  last_lap;
  time_t  best_lap;
  count_t laps;
  level_t last_level;
  level_t peak_level;
  time_t  peak_stamp;
  time_t  first_stamp;
  logic   has_sample;
  time_t  lap_hist [DEPTH];
  int     hist_head;
  int     hist_fill;

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  function automatic void clear_pass_store();
    peak_level  = LEVEL_FLOOR;
    peak_stamp  = '0;
    first_stamp = '0;
    has_sample  = 1'b0;
  endfunction

  function automatic void clear_timer();
    started         = 1'b0;
    prev_pass_stamp = '0;
    last_lap        = '0;
    best_lap        = '0;
    laps            = '0;
    last_level      = LEVEL_FLOOR;
    hist_head       = 0;
    hist_fill       = 0;
    clear_pass_store();
  endfunction

  // Close a gate pass: start timing or complete a lap
  function automatic event_t close_pass();
    event_t ev;
    time_t  pass_stamp;
    time_t  lap;
    ev = EV_NONE;
    if (peak_level > LEVEL_FLOOR) begin
      pass_stamp = use_first_stamp ? first_stamp : peak_stamp;
      if (!started) begin
        started         = 1'b1;
        prev_pass_stamp = pass_stamp;
        ev              = EV_START;
      end else begin
        lap      = pass_stamp - prev_pass_stamp;
        last_lap = lap;
        // drop the oldest lap once the history is full
        if (hist_fill >= DEPTH) begin
          lap_hist[hist_head] = lap;
          hist_head           = (hist_head + 1) % DEPTH;
        end else begin
          lap_hist[(hist_head + hist_fill) % DEPTH] = lap;
          hist_fill++;
        end
        prev_pass_stamp = pass_stamp;
        last_level      = peak_level;
        if (laps == 0 || lap < best_lap) best_lap = lap;
        if (laps != LAP_COUNT_MAX) laps++;
        ev = EV_LAP;
      end
    end
    clear_pass_store();
    return ev;
  endfunction

  function automatic lap_result_t predict_lap_result(func_t f, level_t lv, time_t stamp,
                                                     logic last, index_t idx);
    lap_result_t r;
    r.ev    = EV_NONE;
    r.valid = 1'b0;
    case (f)
      FUNC_SAMPLE: begin
        if (!has_sample) begin
          has_sample  = 1'b1;
          first_stamp = stamp;
        end
        // strict compare keeps the first of equal peaks
        if (lv > peak_level) begin
          peak_level = lv;
          peak_stamp = stamp;
        end
        if (last) r.ev = close_pass();
      end
      FUNC_CLEAR: clear_timer();
      default: ;
    endcase
    r.lap = last_lap;
    if (f == FUNC_READ) begin
      r.ev = EV_READ;
      if (int'(idx) < hist_fill) begin
        r.lap   = lap_hist[(hist_head + int'(idx)) % DEPTH];
        r.valid = 1'b1;
      end else begin
        r.lap = '0;
      end
    end
    r.best  = best_lap;
    r.count = laps;
    r.level = last_level;
    return r;
  endfunction

  // Compare results, then predict the request taken at this edge
  always @(posedge clk) begin
    lap_result_t got;
    lap_result_t want;
    if (rst) begin
      use_first_stamp = 1'b0;
      clear_timer();
      lap_results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{ev: event_res, lap: lap_time, best: best_lap_time, count: lap_count,
                level: lap_level, valid: entry_valid};
        if (lap_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"%0t: result with none due: ev=%0d lap=%0d best=%0d",
                      " count=%0d level=%0d valid=%0b"},
                     $realtime, got.ev, got.lap, got.best, got.count, got.level,
                     got.valid);
        end else begin
          want = lap_results_due.pop_front();
          if (got.ev !== want.ev || got.lap !== want.lap || got.best !== want.best ||
              got.count !== want.count || got.level !== want.level ||
              got.valid !== want.valid) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: expected ev=%0d lap=%0d best=%0d count=%0d level=%0d",
                        " valid=%0b, got ev=%0d lap=%0d best=%0d count=%0d level=%0d",
                        " valid=%0b"},
                       $realtime, want.ev, want.lap, want.best, want.count, want.level,
                       want.valid, got.ev, got.lap, got.best, got.count, got.level,
                       got.valid);
          end
        end
      end
      if (cfg_we) use_first_stamp = cfg_wdata;
      if (in_valid && !in_stall)
        lap_results_due.insert(lap_results_due.size(),
                               predict_lap_result(func, signal_level, sample_time,
                                                  pass_end, history_index));
    end
    pending = lap_results_due.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the lap timer with directed gate passes and randomized pass
// sequences under both timestamp pick modes, with random gaps on the
// request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import rplt_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  logic   clk;
  logic   rst;
  logic   cfg_we;
  logic   cfg_wdata;
  logic   in_valid;
  logic   in_stall;
  func_t  func;
  level_t signal_level;
  time_t  sample_time;
  logic   pass_end;
  index_t history_index;
  logic   out_valid;
  logic   out_stall;
  event_t event_res;
  time_t  lap_time;
  time_t  best_lap_time;
  count_t lap_count;
  level_t lap_level;
  logic   entry_valid;
  int     pending;
  int     fail_count;

  logic   calm;
  time_t  stamp;
  int     quiet;

  rssi_peak_lap_timer_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .signal_level (signal_level),
    .sample_time  (sample_time),
    .pass_end     (pass_end),
    .history_index(history_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .lap_time     (lap_time),
    .best_lap_time(best_lap_time),
    .lap_count    (lap_count),
    .lap_level    (lap_level),
    .entry_valid  (entry_valid)
  );

  lap_timer_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .signal_level (signal_level),
    .sample_time  (sample_time),
    .pass_end     (pass_end),
    .history_index(history_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .lap_time     (lap_time),
    .best_lap_time(best_lap_time),
    .lap_count    (lap_count),
    .lap_level    (lap_level),
    .entry_valid  (entry_valid),
    .pending      (pending),
    .fail_count   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int idle_draw();
    return calm ? 0 : int'($urandom_range(0, 4));
  endfunction

  function automatic level_t rand_level();
    int v;
    v = ($urandom_range(0, 9) == 0) ? -150 : -int'($urandom_range(0, 150));
    return level_t'(v);
  endfunction

  // Advance the sample clock: mostly small steps, some repeats, some jumps
  function automatic time_t next_stamp();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) stamp = $urandom;
    else if (pick != 1) stamp = stamp + $urandom_range(1, 3000);
    return stamp;
  endfunction

  // Present one request after a random gap and hold it until taken.
  // Entered and left at a falling edge.
  task automatic send_req(func_t f, level_t lv, time_t t, logic last, index_t idx);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    signal_level  <= lv;
    sample_time   <= t;
    pass_end      <= last;
    history_index <= idx;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_read(index_t idx);
    send_req(FUNC_READ, rand_level(), $urandom, 1'($urandom_range(0, 1)), idx);
  endtask

  // Drop valid and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(logic first_stamp);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= first_stamp;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    // empty history, both index extremes
    send_read(4'd0);
    send_read(4'd15);
    // pass with nothing above the floor
    send_req(FUNC_SAMPLE, LEVEL_FLOOR, 32'd500, 1'b1, 4'd0);
    // first pass starts timing; equal peaks keep the earlier stamp
    send_req(FUNC_SAMPLE, -9'sd100, 32'd1000, 1'b0, 4'd0);
    send_req(FUNC_SAMPLE, -9'sd40, 32'd1010, 1'b0, 4'd0);
    send_req(FUNC_SAMPLE, -9'sd40, 32'd1020, 1'b0, 4'd0);
    send_req(FUNC_SAMPLE, -9'sd90, 32'd1030, 1'b1, 4'd0);
    // unused function with the stamp, pass end and index at their top
    send_req(FUNC_NONE, 9'sd0, 32'hFFFF_FFFF, 1'b1, 4'd15);
    // long lap, then a lap across the stamp wrap
    send_req(FUNC_SAMPLE, 9'sd0, 32'hFFFF_FF00, 1'b1, 4'd15);
    send_req(FUNC_SAMPLE, -9'sd1, 32'h0000_0100, 1'b1, 4'd7);
    send_read(4'd0);
    send_read(4'd1);
    send_read(4'd2);
    send_req(FUNC_CLEAR, 9'sd0, 32'hFFFF_FFFF, 1'b1, 4'd15);
    send_read(4'd0);
    // first-stamp mode counts floor samples toward the pass start
    write_mode(1'b1);
    send_req(FUNC_SAMPLE, -9'sd149, 32'd5, 1'b0, 4'd0);
    send_req(FUNC_SAMPLE, -9'sd20, 32'd50, 1'b1, 4'd0);
    send_req(FUNC_SAMPLE, LEVEL_FLOOR, 32'd70, 1'b0, 4'd0);
    send_req(FUNC_SAMPLE, -9'sd30, 32'd90, 1'b1, 4'd0);
    send_req(FUNC_SAMPLE, LEVEL_FLOOR, 32'd100, 1'b1, 4'd0);
    send_read(4'd0);
  endtask

  // Mostly complete passes with random content, plus reads, clears and noise
  task automatic run_passes(int n);
    int     sent;
    int     len;
    int     pick;
    logic   flat;
    level_t lv;
    level_t prev_lv;
    sent    = 0;
    prev_lv = LEVEL_FLOOR;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_req(FUNC_CLEAR, rand_level(), $urandom, 1'($urandom_range(0, 1)),
                 index_t'($urandom));
        sent++;
      end else if (pick < 5) begin
        send_req(FUNC_NONE, level_t'($urandom), $urandom, 1'($urandom_range(0, 1)),
                 index_t'($urandom));
      end else if (pick < 15) begin
        send_read(index_t'($urandom));
        sent++;
      end else if (pick < 20) begin
        send_req(FUNC_SAMPLE, rand_level(), next_stamp(), 1'($urandom_range(0, 1)),
                 index_t'($urandom));
        sent++;
      end else begin
        len  = $urandom_range(1, 6);
        flat = ($urandom_range(0, 11) == 0);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_read(index_t'($urandom));
            sent++;
          end
          lv = flat ? LEVEL_FLOOR : rand_level();
          if (!flat && k > 0 && $urandom_range(0, 4) == 0) lv = prev_lv;
          prev_lv = lv;
          send_req(FUNC_SAMPLE, lv, next_stamp(), k == len - 1, index_t'($urandom));
          sent++;
        end
      end
    end
  endtask

  // Result side: random stall before each result
  initial begin
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_valid      = 1'b0;
    func          = FUNC_SAMPLE;
    signal_level  = LEVEL_FLOOR;
    sample_time   = '0;
    pass_end      = 1'b0;
    history_index = '0;
    calm          = 1'b0;
    stamp         = '0;
    quiet         = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      calm = (ph == 2);
      write_mode(ph == 0 ? 1'b0 : (ph == 1 ? 1'b1 : 1'($urandom_range(0, 1))));
      run_passes(150);
    end
    calm = 1'b0;
    write_mode(1'b1);
    run_passes(20);

    // wait out the remaining results
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
